>>> rtl/dcr_pkg.sv
package dcr_pkg;

  // item field widths
  localparam int IDX_W   = 10;
  localparam int COORD_W = 32;
  localparam int MASS_W  = 16;
  localparam int REST_W  = 31;

  localparam int DEFAULT_MAX_POINTS = 1024;

  // command codes carried in tuser
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_INTERNAL = 2'd1;
  localparam logic [1:0] CMD_EXTERNAL = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  // one table entry
  typedef struct packed {
    logic [MASS_W-1:0]  m;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

endpackage

>>> rtl/distance_constraint_relaxation.sv
// operation: a load writes the table entry, a read returns the stored point through the output
//   register; a constraint makes six axis corrections (internal) or three (external), then writes
//   each corrected point back, and writes nothing when the length or the mass sum is zero
// throughput: one item at a time, tready is high only while idle; an unaccepted result holds
//   the sequencer
// reset: synchronous, clears sequencer and output valid; the point table is not cleared
module distance_constraint_relaxation #(
  parameter int MAX_POINTS = dcr_pkg::DEFAULT_MAX_POINTS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_index, second_index, pos_x, pos_y, pos_z, inverse_mass, rest_length, zero pad
  input  logic [167:0] s_tdata,
  // cmd
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_z, out_inverse_mass
  output logic [111:0] m_tdata
);

  localparam int ADDR_W = $clog2(MAX_POINTS);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MOD    = 5'd1;
  localparam logic [4:0] S_LOAD   = 5'd2;
  localparam logic [4:0] S_RD     = 5'd3;
  localparam logic [4:0] S_OUT    = 5'd4;
  localparam logic [4:0] S_C_RD2  = 5'd5;
  localparam logic [4:0] S_C_RD1  = 5'd6;
  localparam logic [4:0] S_C_CAP1 = 5'd7;
  localparam logic [4:0] S_DIFF   = 5'd8;
  localparam logic [4:0] S_SQ     = 5'd9;
  localparam logic [4:0] S_SQRT   = 5'd10;
  localparam logic [4:0] S_CHECK  = 5'd11;
  localparam logic [4:0] S_DEN    = 5'd12;
  localparam logic [4:0] S_EW     = 5'd13;
  localparam logic [4:0] S_NMUL   = 5'd14;
  localparam logic [4:0] S_DIV    = 5'd15;
  localparam logic [4:0] S_APPLY  = 5'd16;
  localparam logic [4:0] S_WR1    = 5'd17;
  localparam logic [4:0] S_WR2    = 5'd18;

  logic [4:0] state, state_next;

  // latched item
  logic [1:0]  cmd;
  logic [9:0]  idx1, idx2;
  logic [31:0] ex, ey, ez;
  logic [15:0] ewt;
  logic [30:0] rest;

  // point table
  dcr_pkg::point_t mem [MAX_POINTS];
  dcr_pkg::point_t mem_q, wr_data;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr, a1, a2;
  logic              mod_start, mod_done;

  // datapath registers
  logic signed [31:0] p1 [3];
  logic signed [31:0] p2 [3];
  logic signed [31:0] np1 [3];
  logic signed [31:0] np2 [3];
  logic [32:0] dmag [3];
  logic [2:0]  dsgn;
  logic [15:0] w1, w2;
  logic [83:0] acc;
  logic [50:0] rem;
  logic [32:0] root;
  logic [6:0]  cnt;
  logic [1:0]  ax, chunk;
  logic        pt;
  logic [49:0] den;
  logic [32:0] emag;
  logic        esgn;
  logic [48:0] ew1, ew2;

  dcr_index_mod #(.MAX_POINTS(MAX_POINTS), .ADDR_W(ADDR_W)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .idx_a  (idx1),
    .idx_b  (idx2),
    .done   (mod_done),
    .addr_a (a1),
    .addr_b (a2)
  );

  assign s_tready  = (state == S_IDLE);
  assign mod_start = (state == S_IDLE) && s_tvalid;

  // table ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_comb begin
    rd_en   = (state == S_RD) || (state == S_C_RD2) || (state == S_C_RD1);
    rd_addr = (state == S_C_RD2) ? a2 : a1;
    wr_en   = (state == S_LOAD) || (state == S_WR1) || (state == S_WR2);
    wr_addr = (state == S_WR2) ? a2 : a1;
    case (state)
      S_LOAD:  wr_data = '{m: ewt, z: ez, y: ey, x: ex};
      S_WR1:   wr_data = '{m: w1, z: np1[2], y: np1[1], x: np1[0]};
      default: wr_data = '{m: w2, z: np2[2], y: np2[1], x: np2[0]};
    endcase
  end

  // shared multiplier and its operand select
  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] prod;
  logic [48:0] ew_sel;
  logic [83:0] addend;
  logic [16:0] wsum;

  assign wsum   = 17'(w1) + 17'(w2);
  assign ew_sel = pt ? ew2 : ew1;

  always_comb begin
    case (state)
      S_SQ: begin
        mul_a = dmag[ax];
        mul_b = (chunk == 2'd0) ? dmag[ax][16:0] : {1'b0, dmag[ax][32:17]};
      end
      S_DEN: begin
        mul_a = root;
        mul_b = wsum;
      end
      S_EW: begin
        mul_a = emag;
        mul_b = {1'b0, pt ? w2 : w1};
      end
      default: begin
        mul_a = dmag[ax];
        case (chunk)
          2'd0:    mul_b = ew_sel[16:0];
          2'd1:    mul_b = ew_sel[33:17];
          default: mul_b = {2'b0, ew_sel[48:34]};
        endcase
      end
    endcase
    prod = 50'(mul_a) * 50'(mul_b);
    case (chunk)
      2'd0:    addend = 84'(prod);
      2'd1:    addend = 84'(prod) << 17;
      default: addend = 84'(prod) << 34;
    endcase
  end

  // per-axis difference
  logic [32:0] dd [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k] = {p2[k][31], p2[k]} - {p1[k][31], p1[k]};
    end
  end

  // square root and divide steps
  logic [50:0] sq_s, sq_t, dv_s, dv_d;
  logic        sq_ge, dv_ge;
  always_comb begin
    sq_s  = {rem[48:0], acc[65:64]};
    sq_t  = 51'({root, 2'b01});
    sq_ge = sq_s >= sq_t;
    dv_s  = {rem[49:0], acc[81]};
    dv_d  = 51'(den);
    dv_ge = dv_s >= dv_d;
  end

  // length error
  logic [33:0] es;
  assign es = {1'b0, root} - {3'b0, rest};

  // capped quotient and saturated new coordinate
  logic [40:0] q41;
  logic        q_big, sub;
  logic signed [31:0] base;
  logic [42:0] sv;
  logic [31:0] sat;
  always_comb begin
    q_big = (|acc[81:41]) || (acc[40] && (|acc[39:0]));
    q41   = q_big ? {1'b1, 40'b0} : acc[40:0];
    sub   = dsgn[ax] ^ esgn ^ pt;
    base  = pt ? p2[ax] : p1[ax];
    sv    = sub ? {{11{base[31]}}, base} - {2'b0, q41}
                : {{11{base[31]}}, base} + {2'b0, q41};
    if (sv[42:31] == 12'h000 || sv[42:31] == 12'hFFF) sat = sv[31:0];
    else if (sv[42]) sat = 32'h8000_0000;
    else sat = 32'h7FFF_FFFF;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_MOD;
      S_MOD: begin
        if (mod_done) begin
          case (cmd)
            dcr_pkg::CMD_LOAD: state_next = S_LOAD;
            dcr_pkg::CMD_READ: state_next = S_RD;
            default:           state_next = S_C_RD2;
          endcase
        end
      end
      S_LOAD:   state_next = S_IDLE;
      S_RD:     state_next = S_OUT;
      S_OUT:    if (!m_tvalid || m_tready) state_next = S_IDLE;
      S_C_RD2:  state_next = S_C_RD1;
      S_C_RD1:  state_next = S_C_CAP1;
      S_C_CAP1: state_next = S_DIFF;
      S_DIFF:   state_next = S_SQ;
      S_SQ:     if (chunk == 2'd1 && ax == 2'd2) state_next = S_SQRT;
      S_SQRT:   if (cnt == 7'd32) state_next = S_CHECK;
      S_CHECK:  state_next = (root == '0 || wsum == '0) ? S_IDLE : S_DEN;
      S_DEN:    state_next = S_EW;
      S_EW:     if (pt) state_next = S_NMUL;
      S_NMUL:   if (chunk == 2'd2) state_next = S_DIV;
      S_DIV:    if (cnt == 7'd81) state_next = S_APPLY;
      S_APPLY: begin
        if (ax != 2'd2 || !pt) state_next = S_NMUL;
        else if (cmd == dcr_pkg::CMD_INTERNAL) state_next = S_WR1;
        else state_next = S_WR2;
      end
      S_WR1:    state_next = S_WR2;
      S_WR2:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd  <= s_tuser;
          idx1 <= s_tdata[9:0];
          idx2 <= s_tdata[19:10];
          ex   <= s_tdata[51:20];
          ey   <= s_tdata[83:52];
          ez   <= s_tdata[115:84];
          ewt  <= s_tdata[131:116];
          rest <= s_tdata[162:132];
        end
      end
      S_C_RD1: begin
        p2[0] <= mem_q.x;
        p2[1] <= mem_q.y;
        p2[2] <= mem_q.z;
        w2    <= mem_q.m;
      end
      S_C_CAP1: begin
        if (cmd == dcr_pkg::CMD_EXTERNAL) begin
          p1[0] <= ex;
          p1[1] <= ey;
          p1[2] <= ez;
          w1    <= ewt;
        end else begin
          p1[0] <= mem_q.x;
          p1[1] <= mem_q.y;
          p1[2] <= mem_q.z;
          w1    <= mem_q.m;
        end
      end
      S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          dsgn[k] <= dd[k][32];
          dmag[k] <= dd[k][32] ? 33'(-dd[k]) : dd[k];
        end
        acc   <= '0;
        ax    <= 2'd0;
        chunk <= 2'd0;
      end
      // sum of squares, two partial products per axis
      S_SQ: begin
        acc <= acc + addend;
        if (chunk == 2'd1) begin
          chunk <= 2'd0;
          ax    <= ax + 2'd1;
          cnt   <= '0;
          rem   <= '0;
          root  <= '0;
        end else begin
          chunk <= 2'd1;
        end
      end
      // two radicand bits per cycle
      S_SQRT: begin
        acc  <= acc << 2;
        cnt  <= cnt + 7'd1;
        rem  <= sq_ge ? sq_s - sq_t : sq_s;
        root <= {root[31:0], sq_ge};
      end
      S_CHECK: begin
        esgn <= es[33];
        emag <= es[33] ? 33'(-es) : es[32:0];
        pt   <= 1'b0;
      end
      S_DEN: den <= prod;
      S_EW: begin
        if (pt) begin
          ew2   <= prod[48:0];
          pt    <= (cmd == dcr_pkg::CMD_EXTERNAL);
          ax    <= 2'd0;
          chunk <= 2'd0;
          acc   <= '0;
        end else begin
          ew1 <= prod[48:0];
          pt  <= 1'b1;
        end
      end
      // numerator, three partial products
      S_NMUL: begin
        acc <= acc + addend;
        if (chunk == 2'd2) begin
          chunk <= 2'd0;
          cnt   <= '0;
          rem   <= '0;
        end else begin
          chunk <= chunk + 2'd1;
        end
      end
      // restoring divide, quotient shifts into the low end
      S_DIV: begin
        acc <= {2'b0, acc[80:0], dv_ge};
        rem <= dv_ge ? dv_s - dv_d : dv_s;
        cnt <= cnt + 7'd1;
      end
      S_APPLY: begin
        if (pt) np2[ax] <= sat;
        else np1[ax] <= sat;
        acc   <= '0;
        chunk <= 2'd0;
        if (ax == 2'd2) begin
          ax <= 2'd0;
          pt <= 1'b1;
        end else begin
          ax <= ax + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {mem_q.m, mem_q.z, mem_q.y, mem_q.x};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> rtl/dcr_index_mod.sv
module dcr_index_mod #(
  parameter int MAX_POINTS = dcr_pkg::DEFAULT_MAX_POINTS,
  parameter int ADDR_W     = $clog2(MAX_POINTS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [dcr_pkg::IDX_W-1:0] idx_a,
  input  logic [dcr_pkg::IDX_W-1:0] idx_b,
  output logic                     done,
  output logic [ADDR_W-1:0]        addr_a,
  output logic [ADDR_W-1:0]        addr_b
);

  localparam logic [19:0] RECIP = 20'((1 << 20) / MAX_POINTS);
  localparam logic [26:0] MOD_C = 27'(MAX_POINTS);

  logic        running;
  logic [29:0] pa, pb;
  logic [26:0] ta, tb, ra, rb;

  // reciprocal quotient estimate, low by at most one, then a single fixup
  always_comb begin
    pa = 30'(idx_a) * 30'(RECIP);
    pb = 30'(idx_b) * 30'(RECIP);
    ta = 27'(idx_a) - 27'(pa[29:20]) * MOD_C;
    tb = 27'(idx_b) - 27'(pb[29:20]) * MOD_C;
    ra = (ta >= MOD_C) ? ta - MOD_C : ta;
    rb = (tb >= MOD_C) ? tb - MOD_C : tb;
  end

  // indices latched by the parent with start are reduced in the cycle after; done is registered with them
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      running <= start;
      done    <= running;
      if (running) begin
        addr_a <= ADDR_W'(ra);
        addr_b <= ADDR_W'(rb);
      end
    end
  end

endmodule

>>> dv/dcr_checker.sv
module dcr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  output int           errors,
  output int           pending
);

  localparam int NPTS = dcr_pkg::DEFAULT_MAX_POINTS;

  // shadow copy of the point table
  dcr_pkg::point_t shadow [NPTS];
  dcr_pkg::point_t read_q [$];

  function automatic logic [69:0] mag_of(longint v);
    return (v < 0) ? 70'(-v) : 70'(v);
  endfunction

  // floor square root of the summed squared distance
  function automatic logic [69:0] floor_root(logic [69:0] s);
    logic [69:0] res;
    logic [69:0] t;
    res = '0;
    for (int b = 34; b >= 0; b--) begin
      t = res | (70'd1 << b);
      if (t * t <= s) res = t;
    end
    return res;
  endfunction

  // signed share of the length error on one axis, toward zero, capped at 2^40
  function automatic longint axis_shift(longint d, longint e, logic [16:0] w,
                                        logic [127:0] den);
    logic [127:0] num;
    logic [127:0] q;
    num = 128'(mag_of(d)) * (128'(mag_of(e)) * 128'(w));
    q = num / den;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return ((d < 0) != (e < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // move one or both ends toward the rest length
  task automatic relax_pair(logic external, logic [167:0] it);
    logic [9:0]   i1, i2;
    longint       p1 [3], p2 [3], d [3];
    logic [16:0]  w1, w2, wsum;
    logic [69:0]  sq, len;
    logic [127:0] den;
    longint       e;
    i1 = it[9:0];
    i2 = it[19:10];
    if (external) begin
      p1[0] = longint'($signed(it[51:20]));
      p1[1] = longint'($signed(it[83:52]));
      p1[2] = longint'($signed(it[115:84]));
      w1 = {1'b0, it[131:116]};
    end else begin
      p1[0] = longint'($signed(shadow[i1].x));
      p1[1] = longint'($signed(shadow[i1].y));
      p1[2] = longint'($signed(shadow[i1].z));
      w1 = {1'b0, shadow[i1].m};
    end
    p2[0] = longint'($signed(shadow[i2].x));
    p2[1] = longint'($signed(shadow[i2].y));
    p2[2] = longint'($signed(shadow[i2].z));
    w2 = {1'b0, shadow[i2].m};
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = p2[k] - p1[k];
      sq = sq + mag_of(d[k]) * mag_of(d[k]);
    end
    len = floor_root(sq);
    wsum = w1 + w2;
    if (len == 0 || wsum == 0) return;
    e = longint'(len) - longint'({33'd0, it[162:132]});
    den = 128'(len) * 128'(wsum);
    if (!external) begin
      shadow[i1].x = clamp32(p1[0] + axis_shift(d[0], e, w1, den));
      shadow[i1].y = clamp32(p1[1] + axis_shift(d[1], e, w1, den));
      shadow[i1].z = clamp32(p1[2] + axis_shift(d[2], e, w1, den));
    end
    shadow[i2].x = clamp32(p2[0] - axis_shift(d[0], e, w2, den));
    shadow[i2].y = clamp32(p2[1] - axis_shift(d[1], e, w2, den));
    shadow[i2].z = clamp32(p2[2] - axis_shift(d[2], e, w2, den));
  endtask

  assign pending = read_q.size();

  initial errors = 0;

  // predict on each accepted input item
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      case (s_tuser)
        dcr_pkg::CMD_LOAD: begin
          shadow[s_tdata[9:0]] = '{m: s_tdata[131:116], z: s_tdata[115:84],
                                   y: s_tdata[83:52], x: s_tdata[51:20]};
        end
        dcr_pkg::CMD_INTERNAL: relax_pair(1'b0, s_tdata);
        dcr_pkg::CMD_EXTERNAL: relax_pair(1'b1, s_tdata);
        dcr_pkg::CMD_READ: read_q.push_back(shadow[s_tdata[9:0]]);
        default: ;
      endcase
    end
  end

  // compare each returned point with the oldest prediction
  always @(posedge clk) begin
    dcr_pkg::point_t want;
    dcr_pkg::point_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m: m_tdata[111:96], z: m_tdata[95:64], y: m_tdata[63:32], x: m_tdata[31:0]};
      if (read_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected point out: %h", got);
      end else begin
        want = read_q.pop_front();
        if (want !== got) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("point mismatch: x %h/%h y %h/%h z %h/%h m %h/%h (want/got)",
                     want.x, got.x, want.y, got.y, want.z, got.z, want.m, got.m);
        end
      end
    end
  end

endmodule

>>> dv/tb_distance_constraint_relaxation.sv
module tb_distance_constraint_relaxation;

  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;
  int           errors;
  int           pending;
  int           idle_cycles;
  logic         steady_in;
  logic         steady_out;
  int           n_by_cmd [4];
  logic [9:0]   loaded [$];

  distance_constraint_relaxation dut (.*);

  dcr_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles with no item accepted on either side
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall per item
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = steady_out ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [9:0] i1, logic [9:0] i2,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] m, logic [30:0] rest);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'd0, rest, m, z, y, x, i2, i1};
    do @(posedge clk); while (!s_tready);
    n_by_cmd[cmd]++;
    if (cmd == dcr_pkg::CMD_LOAD) loaded.push_back(i1);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000);
      default: return 32'($signed($urandom_range(0, 32'h3ff_ffff)) - 32'sh200_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_rest();
    return ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h3ff_ffff));
  endfunction

  function automatic logic [9:0] any_loaded();
    return loaded[$urandom_range(0, loaded.size() - 1)];
  endfunction

  initial begin
    logic [1:0] cmd;
    int pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = dcr_pkg::CMD_LOAD;
    steady_in = 1'b0;
    steady_out = 1'b0;
    foreach (n_by_cmd[k]) n_by_cmd[k] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and each special case
    send_item(dcr_pkg::CMD_LOAD, 10'd0, 10'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
              16'hffff, 31'd0);
    send_item(dcr_pkg::CMD_LOAD, 10'd1023, 10'd0, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 16'h0000, 31'd0);
    send_item(dcr_pkg::CMD_READ, 10'd0, 10'd0, '0, '0, '0, '0, '0);
    send_item(dcr_pkg::CMD_READ, 10'd1023, 10'd0, '0, '0, '0, '0, '0);
    // far apart with the largest rest length; only the end with mass moves
    send_item(dcr_pkg::CMD_INTERNAL, 10'd0, 10'd1023, '0, '0, '0, '0, 31'h7fff_ffff);
    send_item(dcr_pkg::CMD_READ, 10'd0, 10'd0, '0, '0, '0, '0, '0);
    send_item(dcr_pkg::CMD_READ, 10'd1023, 10'd0, '0, '0, '0, '0, '0);
    // same index at both ends
    send_item(dcr_pkg::CMD_INTERNAL, 10'd0, 10'd0, '0, '0, '0, '0, 31'd100);
    // two massless points
    send_item(dcr_pkg::CMD_LOAD, 10'd5, 10'd0, 32'h1_0000, 32'h2_0000, 32'h3_0000,
              16'h0, 31'd0);
    send_item(dcr_pkg::CMD_LOAD, 10'd10, 10'd0, 32'h4_0000, 32'h2_0000, 32'h3_0000,
              16'h0, 31'd0);
    send_item(dcr_pkg::CMD_INTERNAL, 10'd5, 10'd10, '0, '0, '0, '0, 31'h1_0000);
    // coincident points with mass
    send_item(dcr_pkg::CMD_LOAD, 10'd512, 10'd0, 32'h1_0000, 32'h2_0000, 32'h3_0000,
              16'h1000, 31'd0);
    send_item(dcr_pkg::CMD_INTERNAL, 10'd5, 10'd512, '0, '0, '0, '0, 31'h1_0000);
    send_item(dcr_pkg::CMD_INTERNAL, 10'd512, 10'd10, '0, '0, '0, '0, 31'h1_8000);
    send_item(dcr_pkg::CMD_READ, 10'd512, 10'd0, '0, '0, '0, '0, '0);
    send_item(dcr_pkg::CMD_READ, 10'd10, 10'd0, '0, '0, '0, '0, '0);
    // external point, with and without mass
    send_item(dcr_pkg::CMD_EXTERNAL, 10'd0, 10'd512, 32'h0, 32'h0, 32'h0, 16'h2000,
              31'h2_0000);
    send_item(dcr_pkg::CMD_EXTERNAL, 10'd1023, 10'd10, 32'hffff_0000, 32'h0, 32'h0,
              16'h0, 31'd0);
    send_item(dcr_pkg::CMD_EXTERNAL, 10'd0, 10'd512, 32'h1_0000, 32'h2_0000, 32'h3_0000,
              16'hffff, 31'd5);
    send_item(dcr_pkg::CMD_READ, 10'd512, 10'd0, '0, '0, '0, '0, '0);
    send_item(dcr_pkg::CMD_READ, 10'd10, 10'd0, '0, '0, '0, '0, '0);

    // random: loads into random spots mixed with constraints and reads among loaded points
    for (int n = 0; n < 730; n++) begin
      if (n % 60 == 0) begin
        steady_in  = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      cmd = (pick < 18) ? dcr_pkg::CMD_LOAD : (pick < 55) ? dcr_pkg::CMD_INTERNAL :
            (pick < 75) ? dcr_pkg::CMD_EXTERNAL : dcr_pkg::CMD_READ;
      if (cmd == dcr_pkg::CMD_LOAD)
        send_item(cmd, 10'($urandom()), 10'($urandom()), rand_coord(), rand_coord(),
                  rand_coord(), 16'($urandom()), 31'($urandom()));
      else
        send_item(cmd, any_loaded(), any_loaded(), rand_coord(), rand_coord(),
                  rand_coord(), ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom()),
                  rand_rest());
    end
    s_tvalid <= 1'b0;

    // drain, then allow for a constraint still in flight
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);

    $display("covered %0d loads, %0d internal and %0d external constraints, %0d reads",
             n_by_cmd[dcr_pkg::CMD_LOAD], n_by_cmd[dcr_pkg::CMD_INTERNAL],
             n_by_cmd[dcr_pkg::CMD_EXTERNAL], n_by_cmd[dcr_pkg::CMD_READ]);
    $display("random gaps on both channels with stretches of back-to-back traffic");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dcr_pkg.sv
rtl/dcr_index_mod.sv
rtl/distance_constraint_relaxation.sv
dv/dcr_checker.sv
dv/tb_distance_constraint_relaxation.sv
